// File: rtl/gle_pkg.sv
`default_nettype none
package gle_pkg;

  localparam int PIX_W  = 8;
  localparam int CODE_W = 12;
  localparam int CS_W   = 4;
  localparam int BC_W   = 5;
  localparam int ACC_W  = 24;
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [CS_W-1:0] CS_RESET = 4'd8;
  localparam logic [CS_W-1:0] CS_MIN   = 4'd2;
  localparam logic [CS_W-1:0] CS_MAX   = 4'd8;

  localparam logic [APB_AW-1:0] REG_CODE_SIZE = 2'd0;

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_CLEAR,
    SEL_END
  } code_sel_e;

  // what to do once the bytes of an emitted code are out
  typedef enum logic [2:0] {
    RET_FIRST,
    RET_MISS,
    RET_FULL,
    RET_FIN1,
    RET_FIN2
  } ret_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_EMIT,
    S_DRAIN,
    S_MISS_UPD,
    S_TAIL
  } state_e;

  typedef struct packed {
    logic      load;
    logic      start;
    logic      emit;
    code_sel_e sel;
    logic      push;
    logic      push_last;
    logic      set_prefix_pix;
    logic      hash_init;
    logic      probe_step;
    logic      hit_prefix;
    logic      miss;
    logic      miss_slot;
    logic      miss_upd;
    logic      finish;
    logic      clr_wr;
  } gle_cmd_t;

  typedef struct packed {
    logic first_pending;
    logic last;
    logic bc_ge8;
    logic bc_gt8;
    logic bc_nz;
    logic out_free;
    logic slot_empty;
    logic slot_match;
    logic tries_last;
    logic table_full;
    logic clr_last;
  } gle_sts_t;

  function automatic int hash_shift(int depth);
    int f;
    int s;
    f = depth;
    s = 0;
    while (f < 65536) begin
      f = f * 2;
      s = s + 1;
    end
    s = 8 - s;
    return (s < 0) ? 0 : s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/gle_stream_if.sv
`default_nettype none
interface gle_pix_if import gle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             last_pixel;
  modport source (output valid, pixel, last_pixel, input ready);
  modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface gle_byte_if import gle_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/gif_lzw_encoder.sv
`default_nettype none
// Channel    | Dir | Handshake     | Beat payload
// pixel_i    | in  | valid / ready | pixel[7:0], last_pixel
// byte_o     | out | valid / ready | out_byte[7:0], last_byte
// APB        | in  | psel/penable  | code_size at byte address 0, 4 bits
//
// A pixel passes S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK and S_TAIL when
// its string is found at the first hash probe; each further probe adds one
// dictionary RAM read and one compare. Each emitted code adds S_EMIT and
// S_DRAIN, pushing one byte at a time, stalled by byte_o.ready; a miss adds
// S_MISS_UPD to store the new string. After reset, after every image and
// each dictionary-full clear the table is wiped with pixel_i.ready low, one
// slot a cycle. Reset is asynchronous, active low; code_size returns to 8.
module gif_lzw_encoder import gle_pkg::*; #(
  parameter int HASH_DEPTH    = 5003,
  parameter int MAX_CODE_BITS = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  gle_pix_if.sink                pixel_i,
  gle_byte_if.source             byte_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready
);

  logic [CS_W-1:0] code_size_q;
  gle_cmd_t        cmd;
  gle_sts_t        sts;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_CODE_SIZE) ? APB_DW'(code_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_size_q <= CS_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_CODE_SIZE)) begin
      code_size_q <= pwdata[CS_W-1:0];
    end
  end

  gle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pixel_i.valid),
    .in_ready_o (pixel_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gle_datapath #(
    .HASH_DEPTH    (HASH_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .code_size_i  (code_size_q),
    .pixel_i      (pixel_i.pixel),
    .last_pixel_i (pixel_i.last_pixel),
    .out_valid_o  (byte_o.valid),
    .out_ready_i  (byte_o.ready),
    .out_byte_o   (byte_o.out_byte),
    .out_last_o   (byte_o.last_byte)
  );

endmodule
`default_nettype wire

// File: rtl/gle_ram.sv
`default_nettype none
module gle_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 5003
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/gle_ctrl.sv
`default_nettype none
module gle_ctrl import gle_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire gle_sts_t sts_i,
  output      gle_cmd_t cmd_o
);

  state_e    state_q, state_d;
  ret_e      ret_q, ret_d;
  code_sel_e sel_q, sel_d;
  logic      need_clr_q, need_clr_d;
  logic      more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      ret_q      <= RET_FIRST;
      sel_q      <= SEL_PREFIX;
      need_clr_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      sel_q      <= sel_d;
      need_clr_q <= need_clr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    sel_d      = sel_q;
    need_clr_d = need_clr_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    // end code drains every remaining bit, other codes whole bytes only
    more = (sel_q == SEL_END) ? sts_i.bc_nz : sts_i.bc_ge8;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.first_pending ? S_START : S_HASH;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        sel_d       = SEL_CLEAR;
        ret_d       = RET_FIRST;
        state_d     = S_EMIT;
      end
      S_HASH: begin
        cmd_o.hash_init = 1'b1;
        state_d         = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_d = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (sts_i.slot_empty || (!sts_i.slot_match && sts_i.tries_last)) begin
          cmd_o.miss      = 1'b1;
          cmd_o.miss_slot = sts_i.slot_empty;
          sel_d           = SEL_PREFIX;
          ret_d           = RET_MISS;
          state_d         = S_EMIT;
        end else if (sts_i.slot_match) begin
          cmd_o.hit_prefix = 1'b1;
          state_d          = S_TAIL;
        end else begin
          cmd_o.probe_step = 1'b1;
          state_d          = S_PROBE_RD;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_DRAIN;
      end
      S_DRAIN: begin
        if (more) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_last = (sel_q == SEL_END) && !sts_i.bc_gt8;
          end
        end else begin
          case (ret_q)
            RET_FIRST: begin
              cmd_o.set_prefix_pix = 1'b1;
              state_d              = S_TAIL;
            end
            RET_MISS: state_d = S_MISS_UPD;
            RET_FULL: state_d = S_TAIL;
            RET_FIN1: begin
              sel_d   = SEL_END;
              ret_d   = RET_FIN2;
              state_d = S_EMIT;
            end
            RET_FIN2: begin
              cmd_o.finish = 1'b1;
              need_clr_d   = 1'b0;
              state_d      = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MISS_UPD: begin
        cmd_o.miss_upd = 1'b1;
        if (sts_i.table_full) begin
          need_clr_d = 1'b1;
          sel_d      = SEL_CLEAR;
          ret_d      = RET_FULL;
          state_d    = S_EMIT;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        if (sts_i.last) begin
          sel_d   = SEL_PREFIX;
          ret_d   = RET_FIN1;
          state_d = S_EMIT;
        end else if (need_clr_q) begin
          need_clr_d = 1'b0;
          state_d    = S_CLEAR;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

`ifndef SYNTH
  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE_CHK) |-> ($past(state_q) == S_PROBE_RD))
    else $error("probe check without a read cycle before it");
  a_idle_table_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !need_clr_q)
    else $error("idle with a table clear still owed");
  a_ready_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("pixel input ready outside idle");
`endif

endmodule
`default_nettype wire

// File: rtl/gle_datapath.sv
`default_nettype none
module gle_datapath import gle_pkg::*; #(
  parameter int HASH_DEPTH    = 5003,
  parameter int MAX_CODE_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire gle_cmd_t         cmd_i,
  output      gle_sts_t         sts_o,
  input  wire logic [CS_W-1:0]  code_size_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic             last_pixel_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [7:0]       out_byte_o,
  output      logic             out_last_o
);

  localparam int AW     = $clog2(HASH_DEPTH);
  localparam int NFW    = MAX_CODE_BITS + 1;
  localparam int KEYW   = PIX_W + MAX_CODE_BITS;
  localparam int RW     = 1 + KEYW + MAX_CODE_BITS;
  localparam int HSHIFT = hash_shift(HASH_DEPTH);
  localparam logic [AW:0]    DEPTH_X   = (AW+1)'(HASH_DEPTH);
  localparam logic [AW-1:0]  DEPTH_M1  = AW'(HASH_DEPTH - 1);
  localparam logic [NFW-1:0] FULL_CODE = NFW'(1) << MAX_CODE_BITS;

  logic [PIX_W-1:0]         pixel_q;
  logic                     last_q;
  logic                     first_pending_q;
  logic [CS_W-1:0]          pb_q;
  logic [MAX_CODE_BITS-1:0] prefix_q;
  logic [NFW-1:0]           nf_q;
  logic [NFW-1:0]           limit_q;
  logic [CS_W-1:0]          cw_q;
  logic                     cp_q;
  logic [ACC_W-1:0]         acc_q;
  logic [BC_W-1:0]          bc_q;
  logic [AW-1:0]            idx_q;
  logic [AW-1:0]            disp_q;
  logic [AW-1:0]            tries_q;
  logic                     have_slot_q;
  logic [AW-1:0]            clr_cnt_q;

  logic [PIX_W-1:0]         pix_m;
  logic [CS_W-1:0]          pb_new;
  logic [CS_W-1:0]          cw_inc;
  logic [CS_W-1:0]          pb_inc;
  logic [NFW-1:0]           clear_nf;
  logic [CODE_W-1:0]        code;
  logic [AW:0]              hraw;
  logic [AW-1:0]            hmod;
  logic [AW-1:0]            idx_next;
  logic [KEYW-1:0]          key;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [RW-1:0]            ram_wdata;
  logic [RW-1:0]            ram_rdata;

  assign pix_m    = PIX_W'(((PIX_W+1)'(1) << pb_q) - (PIX_W+1)'(1)) & pixel_q;
  assign pb_new   = (code_size_i < CS_MIN) ? CS_MIN :
                    (code_size_i > CS_MAX) ? CS_MAX : code_size_i;
  assign cw_inc   = cw_q + CS_W'(1);
  assign pb_inc   = pb_q + CS_W'(1);
  assign clear_nf = NFW'(1) << pb_q;
  assign key      = {pix_m, prefix_q};

  always_comb begin
    case (cmd_i.sel)
      SEL_PREFIX: code = CODE_W'(prefix_q);
      SEL_CLEAR:  code = CODE_W'(1) << pb_q;
      SEL_END:    code = (CODE_W'(1) << pb_q) + CODE_W'(1);
      default:    code = '0;
    endcase
  end

  assign hraw = ((AW+1)'(pix_m) << HSHIFT) ^ (AW+1)'(prefix_q);
  assign hmod = (hraw >= DEPTH_X) ? AW'(hraw - DEPTH_X) : AW'(hraw);
  assign idx_next = (idx_q >= disp_q) ? (idx_q - disp_q)
                  : AW'((AW+1)'(idx_q) + DEPTH_X - (AW+1)'(disp_q));

  assign ram_we    = cmd_i.clr_wr || (cmd_i.miss_upd && have_slot_q && (nf_q < FULL_CODE));
  assign ram_waddr = cmd_i.clr_wr ? clr_cnt_q : idx_q;
  assign ram_wdata = cmd_i.clr_wr ? '0 : {1'b1, key, nf_q[MAX_CODE_BITS-1:0]};

  gle_ram #(
    .WIDTH (RW),
    .DEPTH (HASH_DEPTH)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sts_o               = '0;
    sts_o.first_pending = first_pending_q;
    sts_o.last          = last_q;
    sts_o.bc_ge8        = bc_q >= BC_W'(8);
    sts_o.bc_gt8        = bc_q > BC_W'(8);
    sts_o.bc_nz         = bc_q != '0;
    sts_o.out_free      = !out_valid_o || out_ready_i;
    sts_o.slot_empty    = !ram_rdata[RW-1];
    sts_o.slot_match    = ram_rdata[RW-2 -: KEYW] == key;
    sts_o.tries_last    = tries_q == DEPTH_M1;
    sts_o.table_full    = nf_q >= FULL_CODE;
    sts_o.clr_last      = clr_cnt_q == DEPTH_M1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      out_valid_o     <= 1'b0;
      clr_cnt_q       <= '0;
    end else begin
      if (cmd_i.start) begin
        first_pending_q <= 1'b0;
      end else if (cmd_i.finish) begin
        first_pending_q <= 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= (clr_cnt_q == DEPTH_M1) ? '0 : clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pixel_q <= pixel_i;
      last_q  <= last_pixel_i;
    end
    if (cmd_i.start) begin
      pb_q    <= pb_new;
      cw_q    <= pb_new + CS_W'(1);
      limit_q <= (NFW'(1) << (pb_new + CS_W'(1))) - NFW'(1);
      nf_q    <= (NFW'(1) << pb_new) + NFW'(2);
      cp_q    <= 1'b0;
      acc_q   <= '0;
      bc_q    <= '0;
    end
    if (cmd_i.emit) begin
      acc_q <= (acc_q & ((ACC_W'(1) << bc_q) - ACC_W'(1))) | (ACC_W'(code) << bc_q);
      bc_q  <= bc_q + BC_W'(cw_q);
      if (cp_q) begin
        cw_q    <= pb_inc;
        limit_q <= (NFW'(1) << pb_inc) - NFW'(1);
        cp_q    <= 1'b0;
      end else if (nf_q > limit_q) begin
        if (cw_inc >= CS_W'(MAX_CODE_BITS)) begin
          cw_q    <= CS_W'(MAX_CODE_BITS);
          limit_q <= FULL_CODE;
        end else begin
          cw_q    <= cw_inc;
          limit_q <= (NFW'(1) << cw_inc) - NFW'(1);
        end
      end
    end
    if (cmd_i.push) begin
      out_byte_o <= acc_q[7:0];
      out_last_o <= cmd_i.push_last;
      acc_q      <= acc_q >> 8;
      bc_q       <= (bc_q >= BC_W'(8)) ? bc_q - BC_W'(8) : '0;
    end
    if (cmd_i.finish) begin
      acc_q <= '0;
      bc_q  <= '0;
    end
    if (cmd_i.hash_init) begin
      idx_q   <= hmod;
      disp_q  <= (hmod == '0) ? AW'(1) : AW'(DEPTH_X - (AW+1)'(hmod));
      tries_q <= '0;
    end
    if (cmd_i.probe_step) begin
      idx_q   <= idx_next;
      tries_q <= tries_q + AW'(1);
    end
    if (cmd_i.miss) begin
      have_slot_q <= cmd_i.miss_slot;
    end
    if (cmd_i.hit_prefix) begin
      prefix_q <= ram_rdata[MAX_CODE_BITS-1:0];
    end
    if (cmd_i.set_prefix_pix) begin
      prefix_q <= MAX_CODE_BITS'(pix_m);
    end
    if (cmd_i.miss_upd) begin
      prefix_q <= MAX_CODE_BITS'(pix_m);
      if (nf_q < FULL_CODE) begin
        if (have_slot_q) begin
          nf_q <= nf_q + NFW'(1);
        end
      end else begin
        nf_q <= clear_nf + NFW'(2);
        cp_q <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_o || out_ready_i))
    else $error("byte pushed over a waiting byte");
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (bc_q < BC_W'(8)))
    else $error("code packed before whole bytes were drained");
  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push || cmd_i.emit) |-> (bc_q < BC_W'(20)))
    else $error("bit accumulator over its bound");
`endif

endmodule
`default_nettype wire
